/* hdl/gyro_bias_two_stage_calibrator_top_assert.svh */
// Assertion macros for the gyro bias calibrator.
// Both macros sample on clk_i of the including module.
`ifndef GYRO_BIAS_TWO_STAGE_CALIBRATOR_TOP_ASSERT_SVH
`define GYRO_BIAS_TWO_STAGE_CALIBRATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define GBC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define GBC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define GBC_ASSERT(label, prop)
`define GBC_ASSERT_ALWAYS(label, prop)
`endif

`endif

/* hdl/gbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gbc_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned GyroW   = 16;
  localparam int unsigned SumW    = 32;
  localparam int unsigned OffW    = 32;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned EventW  = 2;

  localparam logic [CfgW-1:0] SkipRst   = 16'd5000;
  localparam logic [CfgW-1:0] CoarseRst = 16'd2000;
  localparam logic [CfgW-1:0] FineRst   = 16'd10000;

  // divider: numerator 2*|sum|*2^16 + n (fine) or 2*|sum| + 4*n (coarse), divisor up to 8*65535
  localparam int unsigned NumW   = 49;
  localparam int unsigned DenW   = 19;
  localparam int unsigned DivCntW = $clog2(NumW);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SKIP   = 2'd0,
    CFG_COARSE = 2'd1,
    CFG_FINE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [PhaseW-1:0] {
    PH_SKIP1  = 3'd0,
    PH_COARSE = 3'd1,
    PH_SKIP2  = 3'd2,
    PH_FINE   = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE    = 2'd0,
    EV_RESTART = 2'd1,
    EV_COARSE  = 2'd2,
    EV_FINE    = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_LOAD = 3'd1,
    S_DIV  = 3'd2,
    S_SAT  = 3'd3,
    S_EMIT = 3'd4
  } state_e;

endpackage

`default_nettype wire

/* hdl/gbc_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface gbc_in_if;
  import gbc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [GyroW-1:0] gyro_x;
  logic signed [GyroW-1:0] gyro_y;
  logic signed [GyroW-1:0] gyro_z;

  modport source (output valid, func, gyro_x, gyro_y, gyro_z, input ready);
  modport sink   (input valid, func, gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface gbc_out_if;
  import gbc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PhaseW-1:0]      phase;
  logic [EventW-1:0]      event_res;
  logic signed [OffW-1:0] offset_x;
  logic signed [OffW-1:0] offset_y;
  logic signed [OffW-1:0] offset_z;

  modport source (output valid, phase, event_res, offset_x, offset_y, offset_z,
                  input ready);
  modport sink   (input valid, phase, event_res, offset_x, offset_y, offset_z,
                  output ready);
endinterface

`default_nettype wire

/* hdl/gyro_bias_two_stage_calibrator_top.sv */
// A sample or restart word goes from accept to S_EMIT and then the output reg; the word
// closing a coarse or fine run first goes through three 49-step restoring divisions run
// one axis after another on a single shared divider (load, 49 steps, saturate).
// One word in flight; the next word is taken while the result waits in the output reg.
// Reset (rst_ni, async, active low): run lengths return to 5000/2000/10000,
// counters and axis sums clear, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module gyro_bias_two_stage_calibrator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gbc_pkg::CfgW-1:0]     cfg_data_i,
  gbc_in_if.sink                       in_i,
  gbc_out_if.source                    out_o
);
  import gbc_pkg::*;

  `include "gyro_bias_two_stage_calibrator_top_assert.svh"

  state_e state_q, state_d;

  logic [CfgW-1:0] cfg_skip_q, cfg_coarse_q, cfg_fine_q;
  logic [CfgW-1:0] skip_cnt_q, coarse_cnt_q, fine_cnt_q;
  logic signed [SumW-1:0] sum_q [3];
  event_e ev_q;
  logic [1:0] axis_q;

  logic [NumW-1:0]    num_q;
  logic [DenW-1:0]    den_q;
  logic [DenW-1:0]    rem_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               neg_q;
  logic signed [OffW-1:0] off_q [3];

  logic                   out_valid_q;
  logic [PhaseW-1:0]      out_phase_q;
  logic [EventW-1:0]      out_event_q;
  logic signed [OffW-1:0] out_off_q [3];

  logic in_ready, acc, out_free, out_load;
  logic in_skip, in_coarse, in_fine, coarse_end, fine_end;
  logic fine_mode;
  phase_e phase_d;

  // divider and saturation datapath
  logic signed [SumW-1:0] sum_sel;
  logic [SumW-1:0]        mag;
  logic [DenW:0]          shifted, diff;
  logic                   ge;
  logic [NumW-1:0]        lim;
  logic [OffW-1:0]        sat;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(NumW - 1);

  assign in_skip    = skip_cnt_q < cfg_skip_q;
  assign in_coarse  = !in_skip && (coarse_cnt_q < cfg_coarse_q);
  assign in_fine    = !in_skip && !in_coarse && (fine_cnt_q < cfg_fine_q);
  assign coarse_end = in_coarse && ((coarse_cnt_q + 16'd1) == cfg_coarse_q);
  assign fine_end   = in_fine && ((fine_cnt_q + 16'd1) == cfg_fine_q);
  assign fine_mode  = (ev_q == EV_FINE);

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    out_free = !out_valid_q || out_o.ready;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          if (!in_i.func && (coarse_end || fine_end)) begin
            state_d = S_LOAD;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (div_cnt_q == DivLast) begin
          state_d = S_SAT;
        end
      end
      S_SAT: state_d = (axis_q == 2'd2) ? S_EMIT : S_LOAD;
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign acc = in_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // phase after the word just handled
  always_comb begin
    if (skip_cnt_q < cfg_skip_q) begin
      phase_d = (coarse_cnt_q >= cfg_coarse_q) ? PH_SKIP2 : PH_SKIP1;
    end else if (coarse_cnt_q < cfg_coarse_q) begin
      phase_d = PH_COARSE;
    end else if (fine_cnt_q < cfg_fine_q) begin
      phase_d = PH_FINE;
    end else begin
      phase_d = PH_DONE;
    end
  end

  assign sum_sel = sum_q[axis_q];
  assign mag     = sum_sel[SumW-1] ? (~sum_sel + 32'd1) : sum_sel;
  assign shifted = {rem_q, num_q[NumW-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};
  assign lim     = fine_mode ? 49'h0_7FFF_FFFF : 49'd32767;

  always_comb begin
    if (neg_q) begin
      if (num_q > (lim + 49'd1)) begin
        sat = ~lim[OffW-1:0];
      end else begin
        sat = ~num_q[OffW-1:0] + 32'd1;
      end
    end else begin
      sat = (num_q > lim) ? lim[OffW-1:0] : num_q[OffW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_skip_q   <= SkipRst;
      cfg_coarse_q <= CoarseRst;
      cfg_fine_q   <= FineRst;
      skip_cnt_q   <= '0;
      coarse_cnt_q <= '0;
      fine_cnt_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
      end
      ev_q   <= EV_NONE;
      axis_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SKIP:   cfg_skip_q   <= cfg_data_i;
          CFG_COARSE: cfg_coarse_q <= cfg_data_i;
          CFG_FINE:   cfg_fine_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc) begin
        axis_q <= '0;
        if (in_i.func) begin
          skip_cnt_q   <= '0;
          coarse_cnt_q <= '0;
          fine_cnt_q   <= '0;
          for (int i = 0; i < 3; i++) begin
            sum_q[i] <= '0;
          end
          ev_q <= EV_RESTART;
        end else if (in_skip) begin
          skip_cnt_q <= skip_cnt_q + 16'd1;
          ev_q       <= EV_NONE;
        end else if (in_coarse || in_fine) begin
          sum_q[0] <= sum_q[0] + {{(SumW-GyroW){in_i.gyro_x[GyroW-1]}}, in_i.gyro_x};
          sum_q[1] <= sum_q[1] + {{(SumW-GyroW){in_i.gyro_y[GyroW-1]}}, in_i.gyro_y};
          sum_q[2] <= sum_q[2] + {{(SumW-GyroW){in_i.gyro_z[GyroW-1]}}, in_i.gyro_z};
          if (in_coarse) begin
            coarse_cnt_q <= coarse_cnt_q + 16'd1;
            if (coarse_end) begin
              ev_q       <= EV_COARSE;
              skip_cnt_q <= '0;
            end else begin
              ev_q <= EV_NONE;
            end
          end else begin
            fine_cnt_q <= fine_cnt_q + 16'd1;
            if (fine_end) begin
              ev_q <= EV_FINE;
            end else begin
              ev_q <= EV_NONE;
            end
          end
        end else begin
          ev_q <= EV_NONE;
        end
      end
      if (state_q == S_SAT) begin
        axis_q <= axis_q + 2'd1;
        // sums are kept until the last axis is divided
        if (axis_q == 2'd2) begin
          for (int i = 0; i < 3; i++) begin
            sum_q[i] <= '0;
          end
        end
      end
    end
  end

  // shared restoring divider, one quotient bit per cycle; num_q turns into the quotient
  always_ff @(posedge clk_i) begin
    if (acc) begin
      for (int i = 0; i < 3; i++) begin
        off_q[i] <= '0;
      end
    end
    case (state_q)
      S_LOAD: begin
        if (fine_mode) begin
          num_q <= {mag, 17'b0} + {33'b0, cfg_fine_q};
          den_q <= {2'b0, cfg_fine_q, 1'b0};
        end else begin
          num_q <= {16'b0, mag, 1'b0} + {31'b0, cfg_coarse_q, 2'b00};
          den_q <= {cfg_coarse_q, 3'b000};
        end
        neg_q     <= !sum_sel[SumW-1] && (sum_sel != '0);
        rem_q     <= '0;
        div_cnt_q <= '0;
      end
      S_DIV: begin
        rem_q     <= ge ? diff[DenW-1:0] : shifted[DenW-1:0];
        num_q     <= {num_q[NumW-2:0], ge};
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      S_SAT: off_q[axis_q] <= sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_phase_q <= phase_d;
      out_event_q <= ev_q;
      for (int i = 0; i < 3; i++) begin
        out_off_q[i] <= off_q[i];
      end
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.phase     = out_phase_q;
  assign out_o.event_res = out_event_q;
  assign out_o.offset_x  = out_off_q[0];
  assign out_o.offset_y  = out_off_q[1];
  assign out_o.offset_z  = out_off_q[2];

  `GBC_ASSERT(a_rem_below_den, (state_q == S_DIV) |-> (rem_q < den_q))
  `GBC_ASSERT(a_div_ends_in_sat, (state_q == S_DIV && div_cnt_q == DivLast) |=> (state_q == S_SAT))
  `GBC_ASSERT(a_restart_clears, (out_load && ev_q == EV_RESTART) |=> (skip_cnt_q == '0 && coarse_cnt_q == '0 && fine_cnt_q == '0))
  `GBC_ASSERT(a_no_div_zero_offs, (out_valid_q && (out_event_q == EV_NONE || out_event_q == EV_RESTART)) |-> (out_off_q[0] == '0 && out_off_q[1] == '0 && out_off_q[2] == '0))

endmodule

`default_nettype wire

/* test/tb_gyro_bias_two_stage_calibrator_top.sv */
`timescale 1ns / 1ps

module tb_gyro_bias_two_stage_calibrator_top;
  import gbc_pkg::*;

  localparam logic FuncSample  = 1'b0;
  localparam logic FuncRestart = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TailCycles  = 200;
  localparam int unsigned RandomWords = 500;

  typedef struct packed {
    logic                    func;
    logic signed [GyroW-1:0] gx;
    logic signed [GyroW-1:0] gy;
    logic signed [GyroW-1:0] gz;
  } gyro_word_t;

  typedef struct packed {
    phase_e                 phase;
    event_e                 ev;
    logic signed [OffW-1:0] ox;
    logic signed [OffW-1:0] oy;
    logic signed [OffW-1:0] oz;
  } offset_word_t;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i  = CFG_SKIP;
  logic [CfgW-1:0]    cfg_data_i = '0;

  gbc_in_if  in_if ();
  gbc_out_if out_if ();

  gyro_bias_two_stage_calibrator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // calibrator model state
  logic [CfgW-1:0] skip_len   = SkipRst;
  logic [CfgW-1:0] coarse_len = CoarseRst;
  logic [CfgW-1:0] fine_len   = FineRst;
  logic [CfgW-1:0] skip_cnt   = '0;
  logic [CfgW-1:0] coarse_cnt = '0;
  logic [CfgW-1:0] fine_cnt   = '0;
  int              acc [3]    = '{0, 0, 0};

  gyro_word_t   samples_todo [$];
  offset_word_t offsets_due  [$];

  int unsigned send_idle_pct = 20;
  int unsigned recv_idle_pct = 57;
  int unsigned errors        = 0;
  int unsigned cycle_cnt     = 0;
  // words queued whose result has not been checked yet
  int unsigned words_pending = 0;

  function automatic phase_e phase_now();
    if (skip_cnt < skip_len)
      return (coarse_cnt >= coarse_len) ? PH_SKIP2 : PH_SKIP1;
    if (coarse_cnt < coarse_len)
      return PH_COARSE;
    if (fine_cnt < fine_len)
      return PH_FINE;
    return PH_DONE;
  endfunction

  // round(-sum * 2^shift / div), ties away from zero, clamped to [lo, hi]
  function automatic logic signed [OffW-1:0] neg_round_div(input int sum,
      input int unsigned shift, input longint unsigned div, input longint lo,
      input longint hi);
    longint          s;
    longint unsigned mag;
    longint unsigned q;
    s = sum;
    if (div == 0)
      div = 1;
    mag = (s < 0) ? -s : s;
    mag = mag << shift;
    q = (2 * mag + div) / (2 * div);
    if (sum > 0) begin
      if (q > longint'(-lo))
        return lo;
      return -longint'(q);
    end
    if (q > hi)
      return hi;
    return q;
  endfunction

  function automatic offset_word_t calib_step(input gyro_word_t w);
    offset_word_t            r;
    logic signed [GyroW-1:0] rate [3];
    rate[0] = w.gx;
    rate[1] = w.gy;
    rate[2] = w.gz;
    r = '0;
    r.ev = EV_NONE;
    if (w.func == FuncRestart) begin
      skip_cnt = '0;
      coarse_cnt = '0;
      fine_cnt = '0;
      acc = '{0, 0, 0};
      r.ev = EV_RESTART;
    end else if (skip_cnt < skip_len) begin
      skip_cnt++;
    end else if (coarse_cnt < coarse_len) begin
      for (int i = 0; i < 3; i++)
        acc[i] += rate[i];
      coarse_cnt++;
      if (coarse_cnt == coarse_len) begin
        r.ox = neg_round_div(acc[0], 0, 4 * longint'(coarse_len), -32768, 32767);
        r.oy = neg_round_div(acc[1], 0, 4 * longint'(coarse_len), -32768, 32767);
        r.oz = neg_round_div(acc[2], 0, 4 * longint'(coarse_len), -32768, 32767);
        r.ev = EV_COARSE;
        skip_cnt = '0;
        acc = '{0, 0, 0};
      end
    end else if (fine_cnt < fine_len) begin
      for (int i = 0; i < 3; i++)
        acc[i] += rate[i];
      fine_cnt++;
      if (fine_cnt == fine_len) begin
        r.ox = neg_round_div(acc[0], 16, fine_len, -64'sd2147483648, 64'sd2147483647);
        r.oy = neg_round_div(acc[1], 16, fine_len, -64'sd2147483648, 64'sd2147483647);
        r.oz = neg_round_div(acc[2], 16, fine_len, -64'sd2147483648, 64'sd2147483647);
        r.ev = EV_FINE;
        acc = '{0, 0, 0};
      end
    end
    r.phase = phase_now();
    return r;
  endfunction

  function automatic logic signed [GyroW-1:0] rand_rate();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 16) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_word(input logic func, input logic signed [GyroW-1:0] x,
      input logic signed [GyroW-1:0] y, input logic signed [GyroW-1:0] z);
    samples_todo.push_back({func, x, y, z});
    words_pending++;
  endtask

  task automatic wait_idle();
    while (words_pending != 0)
      @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_SKIP:   skip_len = data;
      CFG_COARSE: coarse_len = data;
      CFG_FINE:   fine_len = data;
      default: ;
    endcase
  endtask

  // only called while nothing is in flight
  task automatic set_lengths(input logic [CfgW-1:0] sk, input logic [CfgW-1:0] co,
      input logic [CfgW-1:0] fi);
    cfg_write(CFG_SKIP, sk);
    cfg_write(CFG_COARSE, co);
    cfg_write(CFG_FINE, fi);
    cfg_write(CfgUnused, 16'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
      input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    gyro_word_t w;
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.func   <= FuncSample;
      in_if.gyro_x <= '0;
      in_if.gyro_y <= '0;
      in_if.gyro_z <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        offsets_due.push_back(calib_step(gyro_word_t'({in_if.func, in_if.gyro_x,
                                                       in_if.gyro_y, in_if.gyro_z})));
      if (!in_if.valid || in_if.ready) begin
        if (samples_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          w = samples_todo.pop_front();
          in_if.valid  <= 1'b1;
          in_if.func   <= w.func;
          in_if.gyro_x <= w.gx;
          in_if.gyro_y <= w.gy;
          in_if.gyro_z <= w.gz;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    offset_word_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (offsets_due.size() == 0) begin
          $display("%0t: unexpected word: phase %0d event %0d", $time, out_if.phase,
                   out_if.event_res);
          errors++;
        end else begin
          want = offsets_due.pop_front();
          check_field("phase", want.phase, out_if.phase);
          check_field("event_res", want.ev, out_if.event_res);
          check_field("offset_x", want.ox, out_if.offset_x);
          check_field("offset_y", want.oy, out_if.offset_y);
          check_field("offset_z", want.oz, out_if.offset_z);
        end
        if (words_pending != 0)
          words_pending--;
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("gyro_bias_two_stage_calibrator_top: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned run_len;
    int unsigned sk;
    int unsigned co;
    int unsigned fi;
    int unsigned pick;
    in_if.valid  = 1'b0;
    in_if.func   = FuncSample;
    in_if.gyro_x = '0;
    in_if.gyro_y = '0;
    in_if.gyro_z = '0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset lengths: stays in the first skip
    queue_word(FuncRestart, 16'sh7fff, -16'sd32768, -16'sd1);
    queue_word(FuncSample, 16'sd5, 16'sd6, 16'sd7);
    wait_idle();

    // single-sample runs: half-way rounding, fine saturation, done state
    set_lengths(0, 1, 1);
    queue_word(FuncRestart, 16'sh7fff, -16'sd32768, -16'sd1);
    queue_word(FuncSample, 16'sd2, -16'sd2, 16'sh7fff);
    queue_word(FuncSample, -16'sd32768, 16'sh7fff, 16'sd0);
    queue_word(FuncSample, 16'sd1, 16'sd1, 16'sd1);
    wait_idle();

    set_lengths(2, 3, 3);
    queue_word(FuncRestart, 16'sd0, 16'sd0, 16'sd0);
    queue_word(FuncSample, -16'sd32768, -16'sd32768, -16'sd32768);
    queue_word(FuncSample, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_word(FuncSample, 16'sd6, -16'sd6, 16'sh7fff);
    queue_word(FuncSample, 16'sd0, 16'sd0, 16'sh7fff);
    queue_word(FuncSample, 16'sd0, 16'sd0, 16'sh7fff);
    queue_word(FuncSample, 16'sd9, 16'sd9, 16'sd9);
    queue_word(FuncSample, 16'sd9, 16'sd9, 16'sd9);
    queue_word(FuncSample, 16'sd1, -16'sd1, -16'sd32768);
    queue_word(FuncSample, 16'sd0, 16'sd0, -16'sd32768);
    queue_word(FuncSample, 16'sd0, 16'sd0, -16'sd32768);
    queue_word(FuncRestart, 16'sd0, 16'sd0, 16'sd0);
    wait_idle();

    // empty runs
    set_lengths(0, 0, 0);
    queue_word(FuncSample, 16'sd5, 16'sd5, 16'sd5);
    queue_word(FuncRestart, 16'sd5, 16'sd5, 16'sd5);
    queue_word(FuncSample, 16'sd5, 16'sd5, 16'sd5);
    wait_idle();

    // no coarse run: skip reports the second skip, then fine
    set_lengths(3, 0, 2);
    queue_word(FuncRestart, 16'sd0, 16'sd0, 16'sd0);
    repeat (5) queue_word(FuncSample, rand_rate(), rand_rate(), rand_rate());

    sent = 0;
    while (sent < RandomWords) begin
      wait_idle();
      if (sent < RandomWords / 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 57;
      end else if (sent < 2 * RandomWords / 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(0, 9);
      sk = $urandom_range(0, 3);
      co = $urandom_range(1, 4);
      fi = $urandom_range(1, 4);
      case (pick)
        0: case ($urandom_range(0, 2))
          0: sk = 65535;
          1: co = 65535;
          default: fi = 65535;
        endcase
        1: case ($urandom_range(0, 2))
          0: sk = 0;
          1: co = 0;
          default: fi = 0;
        endcase
        2: case ($urandom_range(0, 2))
          0: sk = $urandom_range(0, 65535);
          1: co = $urandom_range(0, 65535);
          default: fi = $urandom_range(0, 65535);
        endcase
        default: ;
      endcase
      set_lengths(sk, co, fi);
      if (pick == 3) begin
        // noise
        repeat (12) queue_word(1'($urandom), rand_rate(), rand_rate(), rand_rate());
        sent += 12;
      end else begin
        run_len = 2 * sk + co + fi;
        if (run_len > 24)
          run_len = 24;
        // sometimes carry on from the previous run under new lengths
        if ($urandom_range(0, 4) != 0) begin
          queue_word(FuncRestart, rand_rate(), rand_rate(), rand_rate());
          sent++;
        end
        repeat (run_len)
          queue_word(($urandom_range(0, 19) == 0) ? FuncRestart : FuncSample,
                     rand_rate(), rand_rate(), rand_rate());
        sent += run_len;
        repeat ($urandom_range(0, 2))
          queue_word(FuncSample, rand_rate(), rand_rate(), rand_rate());
      end
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0)
      $display("gyro_bias_two_stage_calibrator_top: match");
    else
      $display("gyro_bias_two_stage_calibrator_top: mismatch");
    $finish;
  end

endmodule

/* gyro_bias_two_stage_calibrator_top.f */
+incdir+hdl
hdl/gbc_pkg.sv
hdl/gbc_if.sv
hdl/gyro_bias_two_stage_calibrator_top.sv
test/tb_gyro_bias_two_stage_calibrator_top.sv
